FILE: rtl/dvru_pkg.sv
// Shared constants, types and microcode encodings for the route table update block.
package dvru_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int ID_BITS     = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Item function codes (code 3 decodes as a read)
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_ADVERT = 2'd1;

  // Result action codes
  localparam logic [2:0] ACT_KEPT     = 3'd0;
  localparam logic [2:0] ACT_REFRESH  = 3'd1;
  localparam logic [2:0] ACT_REPLACED = 3'd2;
  localparam logic [2:0] ACT_ADDED    = 3'd3;
  localparam logic [2:0] ACT_FULL     = 3'd4;
  localparam logic [2:0] ACT_LOADED   = 3'd5;
  localparam logic [2:0] ACT_READ     = 3'd6;
  localparam logic [2:0] ACT_EMPTY    = 3'd7;

  // One stored route
  typedef struct packed {
    logic [ID_BITS-1:0] net;
    logic [7:0]         distance;
    logic [ID_BITS-1:0] hop;
  } route_t;

  // Datapath operation selected by the current control word
  typedef enum logic [2:0] {
    OP_FETCH,
    OP_DISPATCH,
    OP_SCAN,
    OP_RDADDR,
    OP_LATCH,
    OP_FINISH
  } op_e;

  // Branch condition tested by the current control word
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_IS_READ,
    C_SCAN_DONE,
    C_OUT_FREE
  } cond_e;

  // Program steps
  typedef enum logic [2:0] {
    ST_FETCH,
    ST_DISPATCH,
    ST_SCAN,
    ST_RDADDR,
    ST_RDLATCH,
    ST_FINISH
  } step_e;

  // One control word of the program
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_e t_true;
    step_e t_false;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    op_e op;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic accept;
    logic is_read;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/dvru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dvru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/dvru_useq.sv
// Microcode sequencer: step counter, control-word table and branch logic.
module dvru_useq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dvru_pkg::stat_t stat_i,
  output dvru_pkg::ctrl_t ctrl_o
);

  dvru_pkg::step_e  pc_q, pc_d;
  dvru_pkg::uword_t uw;
  logic             cond_ok;

  // Program table
  function automatic dvru_pkg::uword_t rom(input dvru_pkg::step_e pc);
    dvru_pkg::uword_t w;
    unique case (pc)
      dvru_pkg::ST_FETCH:    w = '{dvru_pkg::OP_FETCH, dvru_pkg::C_ACCEPT,
                                   dvru_pkg::ST_DISPATCH, dvru_pkg::ST_FETCH};
      dvru_pkg::ST_DISPATCH: w = '{dvru_pkg::OP_DISPATCH, dvru_pkg::C_IS_READ,
                                   dvru_pkg::ST_RDADDR, dvru_pkg::ST_SCAN};
      dvru_pkg::ST_SCAN:     w = '{dvru_pkg::OP_SCAN, dvru_pkg::C_SCAN_DONE,
                                   dvru_pkg::ST_FINISH, dvru_pkg::ST_SCAN};
      dvru_pkg::ST_RDADDR:   w = '{dvru_pkg::OP_RDADDR, dvru_pkg::C_ALWAYS,
                                   dvru_pkg::ST_RDLATCH, dvru_pkg::ST_RDLATCH};
      dvru_pkg::ST_RDLATCH:  w = '{dvru_pkg::OP_LATCH, dvru_pkg::C_ALWAYS,
                                   dvru_pkg::ST_FINISH, dvru_pkg::ST_FINISH};
      dvru_pkg::ST_FINISH:   w = '{dvru_pkg::OP_FINISH, dvru_pkg::C_OUT_FREE,
                                   dvru_pkg::ST_FETCH, dvru_pkg::ST_FINISH};
      default:               w = '{dvru_pkg::OP_FETCH, dvru_pkg::C_ACCEPT,
                                   dvru_pkg::ST_DISPATCH, dvru_pkg::ST_FETCH};
    endcase
    return w;
  endfunction

  // Step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= dvru_pkg::ST_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Branch evaluation
  always_comb begin
    uw = rom(pc_q);
    unique case (uw.cond)
      dvru_pkg::C_ALWAYS:    cond_ok = 1'b1;
      dvru_pkg::C_ACCEPT:    cond_ok = stat_i.accept;
      dvru_pkg::C_IS_READ:   cond_ok = stat_i.is_read;
      dvru_pkg::C_SCAN_DONE: cond_ok = stat_i.scan_done;
      dvru_pkg::C_OUT_FREE:  cond_ok = stat_i.out_free;
      default:               cond_ok = 1'b0;
    endcase
    pc_d      = cond_ok ? uw.t_true : uw.t_false;
    ctrl_o.op = uw.op;
  end

endmodule

FILE: rtl/distance_vector_route_update.sv
// Top level of the distance-vector route table update block.
// Holds up to 64 routes (destination, distance, next hop) in one RAM and takes one item
// at a time. A read item reads its slot from the RAM and latches it for the result. A load or
// advertisement item searches the valid entries one per cycle through the RAM's single
// read port, so its search ends at the last valid entry at most, and sooner when the
// destination is found early. A result that waits at the output holds the block in its
// final step until taken.
module distance_vector_route_update (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] net_id_i,
  input  logic [7:0]  hop_distance_i,
  input  logic [15:0] router_id_i,
  input  logic [5:0]  read_index_i,
  input  logic        last_advert_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  slot_o,
  output logic [7:0]  route_distance_o,
  output logic [15:0] route_next_hop_o,
  output logic [15:0] route_net_o,
  output logic [2:0]  action_o,
  output logic        batch_done_o,
  output logic [6:0]  entries_used_o
);

  localparam int IDX_W = dvru_pkg::IDX_W;
  localparam int CNT_W = dvru_pkg::CNT_W;
  localparam int IDB   = dvru_pkg::ID_BITS;

  dvru_pkg::ctrl_t ctrl;
  dvru_pkg::stat_t stat;

  // Item registers
  logic [1:0]     func_q;
  logic [IDB-1:0] net_q;
  logic [7:0]     dist_q;
  logic [IDB-1:0] rtr_q;
  logic [5:0]     ridx_q;
  logic           last_q;

  // Search and table state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] scan_idx_q;
  logic             rd_vld_q;
  logic             found_q;
  logic [IDX_W-1:0] slot_q;
  dvru_pkg::route_t e_q;

  logic             out_valid_q;

  // RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  dvru_pkg::route_t ram_wdata, ram_rdata;

  logic in_acc, is_read, is_advert, hit, scan_end, out_free, finish_fire;
  logic rd_ok, full, cnt_inc, show, wr_req;
  logic [7:0]       nd;
  logic [2:0]       act;
  logic [5:0]       res_slot;
  logic [IDX_W-1:0] wr_addr;
  dvru_pkg::route_t new_route;

  dvru_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  dvru_ram #(
    .WIDTH ($bits(dvru_pkg::route_t)),
    .DEPTH (dvru_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Handshake and status
  assign in_ready_o  = (ctrl.op == dvru_pkg::OP_FETCH);
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_read     = (func_q != dvru_pkg::FUNC_LOAD) && (func_q != dvru_pkg::FUNC_ADVERT);
  assign is_advert   = (func_q == dvru_pkg::FUNC_ADVERT);
  assign hit         = rd_vld_q && (ram_rdata.net == net_q);
  assign scan_end    = (scan_idx_q == cnt_q);
  assign out_free    = !out_valid_q || out_ready_i;
  assign finish_fire = (ctrl.op == dvru_pkg::OP_FINISH) && out_free;

  assign stat.accept    = in_acc;
  assign stat.is_read   = is_read;
  assign stat.scan_done = hit || scan_end;
  assign stat.out_free  = out_free;

  // Read address: search pointer or the requested slot
  assign ram_raddr = (ctrl.op == dvru_pkg::OP_RDADDR) ? IDX_W'(ridx_q)
                                                      : scan_idx_q[IDX_W-1:0];

  // Control state of the search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      unique case (ctrl.op)
        dvru_pkg::OP_FETCH: begin
          scan_idx_q <= '0;
          rd_vld_q   <= 1'b0;
          found_q    <= 1'b0;
        end
        dvru_pkg::OP_SCAN: begin
          priority if (hit) begin
            found_q  <= 1'b1;
            rd_vld_q <= 1'b0;
          end else if (!scan_end) begin
            scan_idx_q <= scan_idx_q + CNT_W'(1);
            rd_vld_q   <= 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item and entry payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= func_i;
      net_q  <= IDB'(net_id_i);
      dist_q <= hop_distance_i;
      rtr_q  <= IDB'(router_id_i);
      ridx_q <= read_index_i;
      last_q <= last_advert_i;
    end
    if ((ctrl.op == dvru_pkg::OP_SCAN) && hit) begin
      e_q    <= ram_rdata;
      slot_q <= IDX_W'(scan_idx_q - CNT_W'(1));
    end
    if (ctrl.op == dvru_pkg::OP_LATCH) begin
      e_q <= ram_rdata;
    end
  end

  // Update decision for the final step
  always_comb begin
    nd = dist_q;
    if (is_advert) begin
      nd = (dist_q == 8'hFF) ? 8'hFF : dist_q + 8'd1;
    end
    rd_ok     = 32'(ridx_q) < 32'(cnt_q);
    full      = (cnt_q == CNT_W'(dvru_pkg::TABLE_DEPTH));
    new_route = e_q;
    wr_req    = 1'b0;
    wr_addr   = slot_q;
    cnt_inc   = 1'b0;
    show      = 1'b1;
    res_slot  = 6'(slot_q);
    act       = dvru_pkg::ACT_KEPT;
    priority if (is_read) begin
      res_slot = ridx_q;
      show     = rd_ok;
      act      = rd_ok ? dvru_pkg::ACT_READ : dvru_pkg::ACT_EMPTY;
    end else if (found_q) begin
      priority if (!is_advert) begin
        new_route = '{net: e_q.net, distance: nd, hop: rtr_q};
        wr_req    = 1'b1;
        act       = dvru_pkg::ACT_LOADED;
      end else if (e_q.hop == rtr_q) begin
        new_route = '{net: e_q.net, distance: nd, hop: e_q.hop};
        wr_req    = 1'b1;
        act       = dvru_pkg::ACT_REFRESH;
      end else if (nd < e_q.distance) begin
        new_route = '{net: e_q.net, distance: nd, hop: rtr_q};
        wr_req    = 1'b1;
        act       = dvru_pkg::ACT_REPLACED;
      end else begin
        act = dvru_pkg::ACT_KEPT;
      end
    end else if (!full) begin
      // append at the first free slot
      new_route = '{net: net_q, distance: nd, hop: rtr_q};
      wr_req    = 1'b1;
      wr_addr   = cnt_q[IDX_W-1:0];
      cnt_inc   = 1'b1;
      res_slot  = 6'(cnt_q);
      act       = is_advert ? dvru_pkg::ACT_ADDED : dvru_pkg::ACT_LOADED;
    end else begin
      show     = 1'b0;
      res_slot = '0;
      act      = dvru_pkg::ACT_FULL;
    end
    cnt_d = cnt_q + CNT_W'(finish_fire && cnt_inc);
  end

  assign ram_we    = finish_fire && wr_req;
  assign ram_waddr = wr_addr;
  assign ram_wdata = new_route;

  // Entry count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (finish_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      slot_o           <= res_slot;
      route_distance_o <= show ? new_route.distance : 8'd0;
      route_next_hop_o <= show ? 16'(new_route.hop) : 16'd0;
      route_net_o      <= show ? 16'(new_route.net) : 16'd0;
      action_o         <= act;
      batch_done_o     <= is_advert && last_q;
      entries_used_o   <= 7'(cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // table never overflows
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(dvru_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  // count grows by at most one per item
  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("entry count jumped");

  // search pointer never runs past the entry count
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == dvru_pkg::OP_SCAN) |-> (scan_idx_q <= cnt_q))
    else $error("search pointer past entry count");

  // only one item in flight
  a_one_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input ready right after acceptance");

  // a result is never written over while it waits
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish_fire |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before taken");
`endif

endmodule

FILE: tb/tb_distance_vector_route_update.sv
// Self-checking testbench for the distance-vector route table update block.

typedef struct packed {
  logic [5:0]  slot;
  logic [7:0]  distance;
  logic [15:0] next_hop;
  logic [15:0] net;
  logic [2:0]  action;
  logic        done;
  logic [6:0]  used;
} route_result_t;

// Shadow route table plus the queue of route results still owed by the block
class route_table_scoreboard;
  logic [15:0]   net_tab [dvru_pkg::TABLE_DEPTH];
  logic [7:0]    dist_tab [dvru_pkg::TABLE_DEPTH];
  logic [15:0]   hop_tab [dvru_pkg::TABLE_DEPTH];
  int            route_count;
  route_result_t expected_routes[$];
  int            mismatches;

  function new();
    route_count = 0;
    mismatches  = 0;
  endfunction

  function int waiting();
    return expected_routes.size();
  endfunction

  // Copy one table slot into a result
  function void show_slot(ref route_result_t r, input int idx);
    r.slot     = 6'(idx);
    r.distance = dist_tab[idx];
    r.next_hop = hop_tab[idx];
    r.net      = net_tab[idx];
  endfunction

  // Apply one accepted item to the shadow table and queue the result it owes
  function void predict_update(logic [1:0] func, logic [15:0] net, logic [7:0] hop_dist,
                               logic [15:0] rtr, logic [5:0] ridx, logic last);
    route_result_t r;
    logic [7:0]    nd;
    int            hit;
    int            k;
    r = '0;
    if (func == dvru_pkg::FUNC_LOAD || func == dvru_pkg::FUNC_ADVERT) begin
      nd = hop_dist;
      if (func == dvru_pkg::FUNC_ADVERT) begin
        // advertised distance plus one, saturating
        nd     = (hop_dist == 8'hFF) ? 8'hFF : hop_dist + 8'd1;
        r.done = last;
      end
      hit = -1;
      for (k = 0; k < route_count; k++)
        if (hit < 0 && net_tab[k] == net) hit = k;
      if (hit >= 0) begin
        if (func == dvru_pkg::FUNC_LOAD) begin
          dist_tab[hit] = nd;
          hop_tab[hit]  = rtr;
          r.action      = dvru_pkg::ACT_LOADED;
        end else if (hop_tab[hit] == rtr) begin
          dist_tab[hit] = nd;
          r.action      = dvru_pkg::ACT_REFRESH;
        end else if (nd < dist_tab[hit]) begin
          dist_tab[hit] = nd;
          hop_tab[hit]  = rtr;
          r.action      = dvru_pkg::ACT_REPLACED;
        end else begin
          r.action = dvru_pkg::ACT_KEPT;
        end
        show_slot(r, hit);
      end else if (route_count < dvru_pkg::TABLE_DEPTH) begin
        net_tab[route_count]  = net;
        dist_tab[route_count] = nd;
        hop_tab[route_count]  = rtr;
        show_slot(r, route_count);
        route_count++;
        r.action = (func == dvru_pkg::FUNC_LOAD) ? dvru_pkg::ACT_LOADED : dvru_pkg::ACT_ADDED;
      end else begin
        // table full: nothing stored, route fields stay zero
        r.action = dvru_pkg::ACT_FULL;
      end
    end else begin
      r.slot = ridx;
      if (ridx < route_count) begin
        show_slot(r, ridx);
        r.action = dvru_pkg::ACT_READ;
      end else begin
        r.action = dvru_pkg::ACT_EMPTY;
      end
    end
    r.used = 7'(route_count);
    expected_routes.push_back(r);
  endfunction

  // Compare one delivered result against the oldest expectation
  function void check_route(route_result_t got);
    route_result_t exp;
    if (expected_routes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: slot %0d action %0d", got.slot, got.action);
      return;
    end
    exp = expected_routes.pop_front();
    if (got.slot != exp.slot || got.distance != exp.distance ||
        got.next_hop != exp.next_hop || got.net != exp.net ||
        got.action != exp.action || got.done != exp.done || got.used != exp.used) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("expected: slot %0d dist %0d hop %h net %h action %0d done %0b used %0d",
                 exp.slot, exp.distance, exp.next_hop, exp.net, exp.action, exp.done,
                 exp.used);
        $display("actual:   slot %0d dist %0d hop %h net %h action %0d done %0b used %0d",
                 got.slot, got.distance, got.next_hop, got.net, got.action, got.done,
                 got.used);
      end
    end
  endfunction
endclass

module tb_distance_vector_route_update;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int QUIET_ITEMS   = 150;
  localparam int DEST_POOL     = 100;
  localparam int NUM_NEIGHBORS = 6;
  localparam int DRAIN_CYCLES  = 100;
  localparam int CYCLE_LIMIT   = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = '0;
  logic [15:0] net_id_i = '0;
  logic [7:0]  hop_distance_i = '0;
  logic [15:0] router_id_i = '0;
  logic [5:0]  read_index_i = '0;
  logic        last_advert_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  slot_o;
  logic [7:0]  route_distance_o;
  logic [15:0] route_next_hop_o;
  logic [15:0] route_net_o;
  logic [2:0]  action_o;
  logic        batch_done_o;
  logic [6:0]  entries_used_o;

  route_table_scoreboard sb;
  logic [15:0] dest_pool [DEST_POOL];
  logic [15:0] neighbors [NUM_NEIGHBORS];
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;
  int          cycle_count = 0;

  distance_vector_route_update DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .func_i, .net_id_i, .hop_distance_i,
    .router_id_i, .read_index_i, .last_advert_i, .out_valid_o, .out_ready_i, .slot_o,
    .route_distance_o, .route_next_hop_o, .route_net_o, .action_o, .batch_done_o,
    .entries_used_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: stall in random bursts
  always @(negedge clk_i) begin
    if (!quiet && stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_route('{slot_o, route_distance_o, route_next_hop_o, route_net_o,
                       action_o, batch_done_o, entries_used_o});
  end

  // Drive one item, starting at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] func, input logic [15:0] net,
                           input logic [7:0] hop_dist, input logic [15:0] rtr,
                           input logic [5:0] ridx, input logic last);
    int gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= func;
    net_id_i       <= net;
    hop_distance_i <= hop_dist;
    router_id_i    <= rtr;
    read_index_i   <= ridx;
    last_advert_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.predict_update(func, net, hop_dist, rtr, ridx, last);
    @(negedge clk_i);
  endtask

  // Mostly short distances, some near saturation, some anywhere
  function automatic logic [7:0] pick_dist();
    case ($urandom_range(0, 7))
      0: return 8'($urandom_range(250, 255));
      1: return 8'($urandom);
      default: return 8'($urandom_range(0, 16));
    endcase
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0, 1: return 0;
      2: return 10;
      default: return 35;
    endcase
  endfunction

  // Random traffic: mostly advertisement batches over a growing set of destinations
  task automatic run_random(input int total);
    int          sent;
    int          kind;
    int          len;
    int          active;
    int          k;
    logic [15:0] rtr;
    logic [15:0] net;
    logic [5:0]  ridx;
    logic [1:0]  func;
    sent = 0;
    while (sent < total) begin
      kind      = $urandom_range(0, 9);
      len       = $urandom_range(1, (kind < 6) ? 8 : 4);
      active    = 20 + (sent * (DEST_POOL - 20)) / total;
      quiet     = (sent >= total - QUIET_ITEMS);
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      rtr       = neighbors[$urandom_range(0, NUM_NEIGHBORS - 1)];
      for (k = 0; k < len; k++) begin
        net  = dest_pool[$urandom_range(0, active - 1)];
        ridx = 6'($urandom);
        case (kind)
          0, 1, 2, 3, 4, 5: begin
            // one neighbor's table, final entry flagged
            send_item(dvru_pkg::FUNC_ADVERT, net, pick_dist(), rtr, ridx, k == len - 1);
          end
          6, 7: begin
            if ($urandom_range(0, 9) == 0) net = 16'($urandom);
            if ($urandom_range(0, 1) == 0) rtr = 16'($urandom);
            send_item(dvru_pkg::FUNC_LOAD, net, pick_dist(), rtr, ridx, 1'($urandom));
          end
          8: begin
            func = ($urandom_range(0, 7) == 0) ? FUNC_SPARE : FUNC_READ;
            if (sb.route_count > 0 && $urandom_range(0, 2) != 0)
              ridx = 6'($urandom_range(0, sb.route_count - 1));
            send_item(func, 16'($urandom), 8'($urandom), 16'($urandom), ridx, 1'($urandom));
          end
          default: begin
            // noise: anything at all, batches left unterminated
            send_item(2'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), ridx,
                      1'($urandom));
          end
        endcase
      end
      sent += len;
    end
  endtask

  initial begin
    int k;
    sb = new();
    for (k = 0; k < DEST_POOL; k++) dest_pool[k] = 16'($urandom);
    for (k = 0; k < NUM_NEIGHBORS; k++) neighbors[k] = 16'($urandom);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty reads, overwrite, refresh, replace, keep, saturation, append
    gap_pct   = 10;
    stall_pct = 10;
    send_item(FUNC_READ, 16'h0000, 8'h00, 16'h0000, 6'd0, 1'b0);
    send_item(FUNC_SPARE, 16'hFFFF, 8'hFF, 16'hFFFF, 6'd63, 1'b1);
    send_item(dvru_pkg::FUNC_LOAD, 16'h0000, 8'd0, 16'h0000, 6'd0, 1'b0);
    send_item(dvru_pkg::FUNC_LOAD, 16'hFFFF, 8'd255, 16'hFFFF, 6'd63, 1'b1);
    send_item(dvru_pkg::FUNC_LOAD, 16'h0000, 8'd10, 16'h1234, 6'd0, 1'b0);
    send_item(dvru_pkg::FUNC_ADVERT, 16'h0000, 8'd20, 16'h1234, 6'd0, 1'b0);
    send_item(dvru_pkg::FUNC_ADVERT, 16'h0000, 8'd3, 16'h00AA, 6'd0, 1'b0);
    send_item(dvru_pkg::FUNC_ADVERT, 16'h0000, 8'd200, 16'h1234, 6'd0, 1'b1);
    send_item(dvru_pkg::FUNC_ADVERT, 16'hFFFF, 8'd255, 16'hFFFF, 6'd0, 1'b0);
    send_item(dvru_pkg::FUNC_ADVERT, 16'h5A5A, 8'd254, 16'h00AA, 6'd0, 1'b1);
    send_item(dvru_pkg::FUNC_ADVERT, 16'hFFFF, 8'd255, 16'h0001, 6'd0, 1'b0);
    send_item(dvru_pkg::FUNC_ADVERT, 16'hFFFF, 8'd253, 16'h0001, 6'd0, 1'b0);
    send_item(dvru_pkg::FUNC_ADVERT, 16'h5A5A, 8'd254, 16'h0002, 6'd0, 1'b1);
    send_item(dvru_pkg::FUNC_ADVERT, 16'hA5A5, 8'd0, 16'hFFFF, 6'd0, 1'b1);
    send_item(FUNC_READ, 16'h0000, 8'h00, 16'h0000, 6'd0, 1'b0);
    send_item(FUNC_READ, 16'h0000, 8'h00, 16'h0000, 6'd3, 1'b0);
    send_item(FUNC_READ, 16'h0000, 8'h00, 16'h0000, 6'd4, 1'b0);
    send_item(FUNC_SPARE, 16'h0000, 8'h00, 16'h0000, 6'd1, 1'b0);

    run_random(RANDOM_ITEMS);
    in_valid_i <= 1'b0;

    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/dvru_pkg.sv
rtl/dvru_ram.sv
rtl/dvru_useq.sv
rtl/distance_vector_route_update.sv
tb/tb_distance_vector_route_update.sv
